### rtl/core/srr_pkg.sv
package srr_pkg;

	localparam int WINDOW_SIZE_D   = 6;
	localparam int SEQ_SPACE_D     = 12;
	localparam int PAYLOAD_BYTES_D = 20;

	localparam int NUM_BEATS = 3;
	localparam int BEAT_W    = 64;
	localparam int ZERO_CHAR = 48;

	localparam logic [1:0] BEAT_FIRST = 2'd0;
	localparam logic [1:0] BEAT_MID   = 2'd1;
	localparam logic [1:0] BEAT_LAST  = 2'd2;
	localparam logic [1:0] BEAT_NONE  = 2'd3;

	typedef struct packed {
		logic [3:0]  seq;
		logic [31:0] ackf;
		logic [31:0] csf;
		logic [31:0] part;   // byte sum of the whole payload
	} hdr_t;

	function automatic logic [BEAT_W-1:0] beat_mask(input int beat, input int nbytes);
		logic [BEAT_W-1:0] m;
		m = '0;
		for (int k = 0; k < 8; k++) begin
			if (8 * beat + k < nbytes) begin
				m[8*k +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

### rtl/core/sr_receiver_reorder.sv
// Selective-repeat receiver with an in-order reorder store.
// Input stream: one item per 64-bit payload beat; a packet is three beats
// (index 0, 1, 2), header fields are taken with beat 2. Index 3 is dropped.
// Output stream: for every beat 2, one ACK item (m_tuser = 0), then any
// packets now in order as data items (m_tuser = 1), three per packet.
// m_tlast marks the last output item caused by that input beat.
// Beats 0, 1 and 3 are taken back to back.
// After beat 2 the block passes ST_CHECK, then ST_WRITE when the packet is
// written into the store (three store writes, one per cycle), then ST_ACK,
// which loads the ACK into the output register. A data word is delivered by
// a store read, then an output register load; the store read port is registered.
// s_tready is low from beat 2 until the last result is loaded.
// A result waits in the output register while m_tready is low; the block
// holds its sequence until the register frees up.
// Reset clears receive marks and the expected number and sets the ACK bit to
// one; the store itself is not cleared, entries are read only after written.
module sr_receiver_reorder import srr_pkg::*; #(
	parameter int WINDOW_SIZE   = WINDOW_SIZE_D,
	parameter int SEQ_SPACE     = SEQ_SPACE_D,
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_D
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// seq_num[3:0], ack_field[35:4], checksum_field[67:36],
	// payload_word[131:68], word_index[133:132], zero pad
	input  logic [135:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// ack_number[3:0], ack_seq_bit[4], ack_checksum[14:5], delivered_seq[18:15],
	// data_word[82:19], out_word_index[84:83], zero pad
	output logic [87:0]  m_tdata,
	// kind[0]
	output logic         m_tuser,
	output logic         m_tlast
);

	localparam int DEPTH = NUM_BEATS * SEQ_SPACE;
	localparam int AW    = $clog2(DEPTH);

	logic              take;
	hdr_t              hdr;
	logic [BEAT_W-1:0] beat_word;
	logic [1:0]        rd_beat;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [BEAT_W-1:0] ram_wdata, ram_rdata;

	srr_intake #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_intake (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.seq_num       (s_tdata[3:0]),
		.ack_field     (s_tdata[35:4]),
		.checksum_field(s_tdata[67:36]),
		.payload_word  (s_tdata[131:68]),
		.word_index    (s_tdata[133:132]),
		.rd_beat       (rd_beat),
		.hdr           (hdr),
		.beat_word     (beat_word)
	);

	srr_ram #(
		.WIDTH(BEAT_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	srr_ctrl #(
		.WINDOW_SIZE  (WINDOW_SIZE),
		.SEQ_SPACE    (SEQ_SPACE),
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.word_index(s_tdata[133:132]),
		.s_tready  (s_tready),
		.take      (take),
		.hdr       (hdr),
		.beat_word (beat_word),
		.rd_beat   (rd_beat),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

### rtl/core/srr_ram.sv
module srr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 36,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/srr_intake.sv
module srr_intake import srr_pkg::*; #(
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_D
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [3:0]        seq_num,
	input  logic [31:0]       ack_field,
	input  logic [31:0]       checksum_field,
	input  logic [BEAT_W-1:0] payload_word,
	input  logic [1:0]        word_index,
	input  logic [1:0]        rd_beat,
	output hdr_t              hdr,
	output logic [BEAT_W-1:0] beat_word
);

	localparam logic [BEAT_W-1:0] MASK0 = beat_mask(0, PAYLOAD_BYTES);
	localparam logic [BEAT_W-1:0] MASK1 = beat_mask(1, PAYLOAD_BYTES);
	localparam logic [BEAT_W-1:0] MASK2 = beat_mask(2, PAYLOAD_BYTES);

	logic [BEAT_W-1:0] words_q [NUM_BEATS];
	logic [BEAT_W-1:0] masked;
	logic [10:0]       wsum;
	logic [31:0]       bsum_q;
	hdr_t              hdr_q;

	always_comb begin
		unique case (word_index)
			BEAT_FIRST: masked = payload_word & MASK0;
			BEAT_MID:   masked = payload_word & MASK1;
			BEAT_LAST:  masked = payload_word & MASK2;
			default:    masked = '0;
		endcase
	end

	always_comb begin
		wsum = '0;
		for (int k = 0; k < 8; k++) begin
			wsum = wsum + 11'(masked[8*k +: 8]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsum_q <= '0;
		end else if (take) begin
			if (word_index == BEAT_FIRST) begin
				bsum_q <= 32'(wsum);
			end else if (word_index == BEAT_MID) begin
				bsum_q <= bsum_q + 32'(wsum);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && word_index != BEAT_NONE) begin
			words_q[word_index] <= masked;
		end
		if (take && word_index == BEAT_LAST) begin
			hdr_q.seq  <= seq_num;
			hdr_q.ackf <= ack_field;
			hdr_q.csf  <= checksum_field;
			hdr_q.part <= bsum_q + 32'(wsum);
		end
	end

	assign hdr       = hdr_q;
	assign beat_word = words_q[rd_beat];

endmodule

### rtl/core/srr_ctrl.sv
module srr_ctrl import srr_pkg::*; #(
	parameter int WINDOW_SIZE   = WINDOW_SIZE_D,
	parameter int SEQ_SPACE     = SEQ_SPACE_D,
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_D,
	localparam int AW = $clog2(NUM_BEATS * SEQ_SPACE)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic [1:0]        word_index,
	output logic              s_tready,
	output logic              take,
	input  hdr_t              hdr,
	input  logic [BEAT_W-1:0] beat_word,
	output logic [1:0]        rd_beat,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [BEAT_W-1:0] ram_wdata,
	output logic              ram_re,
	output logic [AW-1:0]     ram_raddr,
	input  logic [BEAT_W-1:0] ram_rdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [87:0]       m_tdata,
	output logic              m_tuser,
	output logic              m_tlast
);

	localparam int SW  = $clog2(SEQ_SPACE);
	localparam int AKW = (SW > 4) ? SW : 4;
	localparam logic [9:0] ACK_BASE = 10'((ZERO_CHAR * PAYLOAD_BYTES) % 1024);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_WRITE = 6'b000100,
		ST_ACK   = 6'b001000,
		ST_RD    = 6'b010000,
		ST_DLV   = 6'b100000
	} state_t;

	state_t             st_q;
	logic [SEQ_SPACE-1:0] marks_q;
	logic [SW-1:0]      exp_q, exp_nx, seq_ix;
	logic [AW-1:0]      base_q, ebase_q, ebase_nx;
	logic [1:0]         cnt_q;
	logic               tog_q;
	logic [AKW-1:0]     ackn_q, ackn_c;
	logic [31:0]        total;
	logic [7:0]         diff, gap;
	logic               corrupt, store_ok, out_free, load_out;

	logic               vld_q, kind_q, bit_q, last_q;
	logic [3:0]         ackn_o_q, dseq_q;
	logic [9:0]         csum_q;
	logic [BEAT_W-1:0]  data_q;
	logic [1:0]         widx_q;

	assign s_tready = (st_q == ST_IDLE);
	assign take     = s_tvalid && s_tready;
	assign out_free = !vld_q || m_tready;
	assign load_out = ((st_q == ST_ACK) || (st_q == ST_DLV)) && out_free;

	// header check
	always_comb begin
		total   = hdr.part + hdr.ackf + 32'(hdr.seq);
		corrupt = (8'(hdr.seq) >= 8'(SEQ_SPACE)) || (total != hdr.csf);
		diff    = 8'(hdr.seq) + 8'(SEQ_SPACE) - 8'(exp_q);
		gap     = (diff >= 8'(SEQ_SPACE)) ? diff - 8'(SEQ_SPACE) : diff;
		seq_ix  = SW'(hdr.seq);
		store_ok = !corrupt && (gap < 8'(WINDOW_SIZE)) && !marks_q[seq_ix];
		if (corrupt) begin
			ackn_c = (exp_q == '0) ? AKW'(SEQ_SPACE - 1) : AKW'(exp_q) - 1'b1;
		end else begin
			ackn_c = AKW'(hdr.seq);
		end
	end

	always_comb begin
		exp_nx   = (exp_q == SW'(SEQ_SPACE - 1)) ? '0 : exp_q + 1'b1;
		ebase_nx = (exp_q == SW'(SEQ_SPACE - 1)) ? '0 : ebase_q + AW'(NUM_BEATS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			marks_q <= '0;
			exp_q   <= '0;
			ebase_q <= '0;
			cnt_q   <= '0;
			tog_q   <= 1'b1;
			vld_q   <= 1'b0;
		end else begin
			vld_q <= load_out || (vld_q && !m_tready);
			unique case (st_q)
				ST_IDLE: begin
					if (take && word_index == BEAT_LAST) begin
						st_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					cnt_q <= '0;
					if (store_ok) begin
						marks_q[seq_ix] <= 1'b1;
						st_q <= ST_WRITE;
					end else begin
						st_q <= ST_ACK;
					end
				end
				ST_WRITE: begin
					if (cnt_q == BEAT_LAST) begin
						cnt_q <= '0;
						st_q  <= ST_ACK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ACK: begin
					if (out_free) begin
						tog_q <= ~tog_q;
						cnt_q <= '0;
						st_q  <= marks_q[exp_q] ? ST_RD : ST_IDLE;
					end
				end
				ST_RD: begin
					st_q <= ST_DLV;
				end
				ST_DLV: begin
					if (out_free) begin
						if (cnt_q == BEAT_LAST) begin
							marks_q[exp_q] <= 1'b0;
							exp_q   <= exp_nx;
							ebase_q <= ebase_nx;
							cnt_q   <= '0;
							st_q    <= marks_q[exp_nx] ? ST_RD : ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
							st_q  <= ST_RD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_CHECK) begin
			ackn_q <= ackn_c;
			base_q <= AW'({seq_ix, 1'b0}) + AW'(seq_ix);
		end
		if (st_q == ST_ACK && out_free) begin
			kind_q   <= 1'b0;
			ackn_o_q <= 4'(ackn_q);
			bit_q    <= tog_q;
			csum_q   <= 10'(tog_q) + 10'(ackn_q) + ACK_BASE;
			dseq_q   <= '0;
			data_q   <= '0;
			widx_q   <= '0;
			last_q   <= !marks_q[exp_q];
		end else if (st_q == ST_DLV && out_free) begin
			kind_q   <= 1'b1;
			ackn_o_q <= '0;
			bit_q    <= 1'b0;
			csum_q   <= '0;
			dseq_q   <= 4'(exp_q);
			data_q   <= ram_rdata;
			widx_q   <= cnt_q;
			last_q   <= (cnt_q == BEAT_LAST) && !marks_q[exp_nx];
		end
	end

	assign rd_beat   = cnt_q;
	assign ram_we    = (st_q == ST_WRITE);
	assign ram_waddr = base_q + AW'(cnt_q);
	assign ram_wdata = beat_word;
	assign ram_re    = (st_q == ST_RD);
	assign ram_raddr = ebase_q + AW'(cnt_q);

	assign m_tvalid = vld_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {3'b000, widx_q, data_q, dseq_q, csum_q, bit_q, ackn_o_q};

endmodule

### rtl/core/srr_checker.sv
module srr_checker import srr_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [135:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [87:0]  m_tdata,
	input logic         m_tuser,
	input logic         m_tlast
);

	// stalled output item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output item changed under stall");

	// a final beat always closes the input until its last result is loaded
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[133:132] == BEAT_LAST |=> !s_tready)
		else $error("input open right after final beat");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[14:0] == '0 && m_tdata[84:83] != BEAT_NONE)
		else $error("data item carries ack fields or bad beat index");

	a_ack_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[84:15] == '0)
		else $error("ack item carries data fields");

endmodule

bind sr_receiver_reorder srr_checker u_chk (.*);
